@@ hw/rtl/aic_pkg.sv @@
// Package with the operation codes, rule codes and decode functions of the instruction classifier.
`default_nettype none
package aic_pkg;

  typedef enum logic [4:0] {
    OP_UNKNOWN = 5'd0, OP_NOP = 5'd1, OP_BRANCH = 5'd2, OP_CALL = 5'd3,
    OP_COND_BRANCH = 5'd4, OP_CMP_BRANCH = 5'd5, OP_BIT_BRANCH = 5'd6,
    OP_IND_BRANCH = 5'd7, OP_IND_CALL = 5'd8, OP_RETURN = 5'd9,
    OP_LOAD = 5'd10, OP_STORE = 5'd11, OP_MOVE_ZERO = 5'd12,
    OP_MOVE_NOT = 5'd13, OP_MOVE_KEEP = 5'd14, OP_MOVE_REG = 5'd15,
    OP_SELECT = 5'd16, OP_SELECT_INC = 5'd17, OP_SELECT_INV = 5'd18,
    OP_SELECT_NEG = 5'd19, OP_ADD = 5'd20, OP_SUB = 5'd21, OP_AND = 5'd22,
    OP_OR = 5'd23, OP_XOR = 5'd24, OP_ADR = 5'd25, OP_ADRP = 5'd26,
    OP_BITFIELD = 5'd27, OP_COMPARE = 5'd28
  } op_e;

  typedef enum logic [4:0] {
    RULE_NONE, RULE_NOP, RULE_B, RULE_BCOND, RULE_CB, RULE_TB, RULE_BR,
    RULE_MOVW, RULE_MOVR, RULE_CSEL, RULE_ADDI, RULE_LOGI, RULE_LOGR,
    RULE_ADDR, RULE_ADR, RULE_LDST, RULE_LIT, RULE_BFM
  } rule_e;

  // Stage one to stage two: the matched rule and the pc-relative offset.
  typedef struct packed {
    rule_e       rule;
    logic [31:0] word;
    logic [63:0] base;
    logic [63:0] offset;
    logic        has_tgt;
  } s1_t;

  // Stage two to stage three: decode and the target add.
  typedef struct packed {
    logic [4:0]  op;
    logic [4:0]  dst;
    logic [4:0]  lft;
    logic [5:0]  rgt;
    logic [3:0]  cond;
    logic [5:0]  bitp;
    logic [5:0]  sh;
    logic [1:0]  sht;
    logic [63:0] imm;
    logic [8:0]  mem;
    logic [7:0]  status;
    logic        has_tgt;
    logic        off_neg;
    logic        imm_is_tgt;
    logic [64:0] sum;
    logic        logi;
    logic        wide;
    logic        bm_n;
    logic [5:0]  bm_r;
    logic [5:0]  bm_s;
  } s2_t;

  function automatic rule_e match_rule(input logic [31:0] w);
    rule_e r;
    r = RULE_NONE;
    if (w == 32'hd503201f) r = RULE_NOP;
    else if ((w & 32'h7c000000) == 32'h14000000) r = RULE_B;
    else if ((w & 32'hff000010) == 32'h54000000) r = RULE_BCOND;
    else if ((w & 32'h7e000000) == 32'h34000000) r = RULE_CB;
    else if ((w & 32'h7e000000) == 32'h36000000) r = RULE_TB;
    else if ((w & 32'hfffffc1f) == 32'hd61f0000 || (w & 32'hfffffc1f) == 32'hd63f0000 ||
             (w & 32'hfffffc1f) == 32'hd65f0000) r = RULE_BR;
    else if ((w & 32'h1f800000) == 32'h12800000) r = RULE_MOVW;
    else if ((w & 32'h7fe0ffe0) == 32'h2a0003e0) r = RULE_MOVR;
    else if ((w & 32'h1fe00800) == 32'h1a800000) r = RULE_CSEL;
    else if ((w & 32'h1f000000) == 32'h11000000) r = RULE_ADDI;
    else if ((w & 32'h1f800000) == 32'h12000000) r = RULE_LOGI;
    else if ((w & 32'h1f200000) == 32'h0a000000) r = RULE_LOGR;
    else if ((w & 32'h1f200000) == 32'h0b000000) r = RULE_ADDR;
    else if ((w & 32'h1f000000) == 32'h10000000) r = RULE_ADR;
    else if (!w[26] && ((w & 32'h3b200c00) == 32'h38200800 ||
             (w & 32'h3b000000) == 32'h39000000 ||
             (w & 32'h3b200c00) == 32'h38000000)) r = RULE_LDST;
    else if ((w & 32'h3b000000) == 32'h18000000 && !w[26]) r = RULE_LIT;
    else if ((w & 32'h1f800000) == 32'h13000000) r = RULE_BFM;
    return r;
  endfunction

  // Expands a logical immediate; the top bit of the result is the success flag.
  function automatic logic [64:0] bitmask_imm(input logic wide, input logic n,
                                              input logic [5:0] immr,
                                              input logic [5:0] imms);
    logic [6:0]  pattern;
    logic [2:0]  len;
    logic [6:0]  size;
    logic [5:0]  level;
    logic [5:0]  s;
    logic [5:0]  r;
    logic [63:0] mask;
    logic [63:0] emask;
    logic [63:0] rot;
    logic [63:0] res;
    logic        ok;
    pattern = {n, ~imms};
    len = 3'd0;
    for (int i = 1; i < 7; i++) begin
      if (pattern[i]) len = 3'(i);
    end
    size = 7'd1 << len;
    level = 6'(size - 7'd1);
    s = imms & level;
    r = immr & level;
    ok = !(!wide && n) && pattern != 7'd0 && len != 3'd0 && !(!wide && size == 7'd64) &&
         s != level;
    mask = (64'd2 << s) - 64'd1;
    emask = (size == 7'd64) ? '1 : ((64'd1 << size) - 64'd1);
    rot = (r == 6'd0) ? mask : (((mask >> r) | (mask << (size - 7'(r)))) & emask);
    res = '0;
    for (int b = 0; b < 64; b++) begin
      if ((wide || b < 32) && rot[6'(b) & level]) res[b] = 1'b1;
    end
    if (!ok) res = '0;
    return {ok, res};
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/aic_decode.sv @@
// Second stage: field decode of the matched rule and the pc-relative target add.
`default_nettype none
module aic_decode
  import aic_pkg::*;
(
  input  var s1_t s1_i,
  output s2_t     s2_o
);

  logic [31:0] w;
  logic [4:0]  rd;
  logic [4:0]  rn;
  logic [4:0]  rm;
  logic [1:0]  size;
  logic [1:0]  kind22;
  logic [1:0]  kind29;
  logic [1:0]  msc;

  assign w = s1_i.word;
  assign rd = w[4:0];
  assign rn = w[9:5];
  assign rm = w[20:16];
  assign size = w[31:30];
  assign kind22 = w[23:22];
  assign kind29 = w[30:29];

  always_comb begin
    s2_o = '0;
    s2_o.has_tgt = s1_i.has_tgt;
    s2_o.off_neg = s1_i.offset[63];
    s2_o.sum = {1'b0, s1_i.base} + {1'b0, s1_i.offset};
    s2_o.status[0] = 1'b1;
    s2_o.status[1] = 1'b1;
    s2_o.wide = w[31];
    s2_o.bm_n = w[22];
    s2_o.bm_r = w[21:16];
    s2_o.bm_s = w[15:10];
    msc = 2'd0;
    unique case (s1_i.rule)
      RULE_NOP: begin
        s2_o.op = OP_NOP;
        s2_o.status[1] = 1'b0;
      end
      RULE_B: begin
        s2_o.op = w[31] ? OP_CALL : OP_BRANCH;
        s2_o.status[2] = w[31];
        s2_o.status[3] = 1'b1;
      end
      RULE_BCOND: begin
        s2_o.op = OP_COND_BRANCH;
        s2_o.cond = w[3:0];
        s2_o.status[3] = 1'b1;
      end
      RULE_CB, RULE_TB: begin
        s2_o.op = (s1_i.rule == RULE_CB) ? OP_CMP_BRANCH : OP_BIT_BRANCH;
        s2_o.lft = rd;
        s2_o.cond = {3'd0, w[24]};
        if (s1_i.rule == RULE_TB) s2_o.bitp = {w[31], w[23:19]};
        s2_o.status[3] = 1'b1;
      end
      RULE_BR: begin
        s2_o.lft = rn;
        s2_o.op = (w[22:21] == 2'd1) ? OP_IND_CALL :
                  ((w[22:21] == 2'd2) ? OP_RETURN : OP_IND_BRANCH);
        s2_o.status[2] = w[22:21] == 2'd1;
        s2_o.status[3] = 1'b1;
      end
      RULE_MOVW: begin
        if (!((!w[31] && w[22]) || kind29 == 2'd1)) begin
          s2_o.op = (kind29 == 2'd0) ? OP_MOVE_NOT :
                    ((kind29 == 2'd2) ? OP_MOVE_ZERO : OP_MOVE_KEEP);
          s2_o.dst = rd;
          s2_o.lft = rn;
          s2_o.rgt = {1'b0, rm};
          s2_o.sh = {w[22:21], 4'd0};
          s2_o.imm = {48'd0, w[20:5]} << {w[22:21], 4'd0};
          s2_o.status[1] = 1'b0;
        end
      end
      RULE_MOVR: begin
        s2_o.op = OP_MOVE_REG;
        s2_o.dst = rd;
        s2_o.lft = rm;
        s2_o.rgt = {1'b0, rm};
        s2_o.status[1] = 1'b0;
      end
      RULE_CSEL: begin
        s2_o.op = w[30] ? (w[10] ? OP_SELECT_NEG : OP_SELECT_INV) :
                          (w[10] ? OP_SELECT_INC : OP_SELECT);
        s2_o.dst = rd;
        s2_o.lft = rn;
        s2_o.rgt = {1'b0, rm};
        s2_o.cond = w[15:12];
        s2_o.status[1] = 1'b0;
      end
      RULE_ADDI, RULE_ADDR: begin
        s2_o.op = (w[29] && rd == 5'd31 && w[30]) ? OP_COMPARE :
                  (w[30] ? OP_SUB : OP_ADD);
        s2_o.dst = rd;
        s2_o.lft = rn;
        if (s1_i.rule == RULE_ADDI) begin
          s2_o.rgt = '1;
          s2_o.imm = {52'd0, w[21:10]} << (w[22] ? 6'd12 : 6'd0);
        end else begin
          s2_o.rgt = {1'b0, rm};
          s2_o.sh = w[15:10];
          s2_o.sht = w[23:22];
        end
        s2_o.status[6] = w[29];
        s2_o.status[1] = 1'b0;
      end
      RULE_LOGI, RULE_LOGR: begin
        s2_o.op = (kind29 == 2'd1) ? OP_OR : ((kind29 == 2'd2) ? OP_XOR : OP_AND);
        s2_o.dst = rd;
        s2_o.lft = rn;
        if (s1_i.rule == RULE_LOGI) begin
          s2_o.rgt = '1;
          s2_o.logi = 1'b1;
        end else begin
          s2_o.rgt = {1'b0, rm};
          s2_o.sh = w[15:10];
          s2_o.sht = w[23:22];
        end
        s2_o.status[6] = kind29 == 2'd3;
        s2_o.status[1] = 1'b0;
      end
      RULE_ADR: begin
        s2_o.op = w[31] ? OP_ADRP : OP_ADR;
        s2_o.dst = rd;
        s2_o.lft = rn;
        s2_o.rgt = {1'b0, rm};
        s2_o.wide = 1'b1;
        s2_o.imm_is_tgt = 1'b1;
        s2_o.status[1] = 1'b0;
      end
      RULE_LDST: begin
        s2_o.op = (kind22 != 2'd0) ? OP_LOAD : OP_STORE;
        s2_o.dst = rd;
        s2_o.lft = rn;
        s2_o.rgt = {1'b0, rm};
        s2_o.wide = kind22 == 2'd2 || size == 2'd3;
        s2_o.mem = {7'd0, size} | {6'd0, kind22[1], 2'd0};
        if ((w & 32'h3b200c00) == 32'h38200800) begin
          msc = w[12] ? size : 2'd0;
          s2_o.mem = s2_o.mem | {msc, w[15:13], 1'b1, 3'd0};
        end else if ((w & 32'h3b000000) == 32'h39000000) begin
          s2_o.imm = {52'd0, w[21:10]} << size;
        end else begin
          s2_o.imm = {{55{w[20]}}, w[20:12]};
        end
        s2_o.status[7] = 1'b1;
        s2_o.status[1] = kind22 == 2'd0 && rn != 5'd31 && rn != 5'd29;
      end
      RULE_LIT: begin
        if (size != 2'd3) begin
          s2_o.op = OP_LOAD;
          s2_o.dst = rd;
          s2_o.lft = rn;
          s2_o.rgt = {1'b0, rm};
          s2_o.mem = {6'd0, size == 2'd2, (size == 2'd1) ? 2'd3 : 2'd2};
          s2_o.status[7] = 1'b1;
          s2_o.wide = size != 2'd0;
          s2_o.status[1] = 1'b0;
        end
      end
      RULE_BFM: begin
        s2_o.op = OP_BITFIELD;
        s2_o.dst = rd;
        s2_o.lft = rn;
        s2_o.rgt = {1'b0, rm};
        s2_o.sh = w[21:16];
        s2_o.bitp = w[15:10];
        s2_o.sht = w[30:29];
        s2_o.status[1] = 1'b0;
      end
      default: begin
      end
    endcase
    if (s2_o.op == OP_UNKNOWN) s2_o.status[0] = 1'b0;
    if (s2_o.status[2]) s2_o.status[6] = 1'b1;
  end

endmodule
`default_nettype wire

@@ hw/rtl/a64_instruction_classifier.sv @@
// Top level of the AArch64 instruction classifier pipeline.
`default_nettype none
// Classifies one AArch64 instruction word per cycle while the output is not stalled and
// gives its fields, immediate and pc-relative target. Three register stages (rule match and
// offset, field decode and target add, bitmask expansion and overflow check) lie between an
// input transfer and its result; a new word can be taken every cycle unless stalled. A stall
// on the output holds every stage in place.
module a64_instruction_classifier
  import aic_pkg::*;
(
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        in_valid_i,
  output logic            in_stall_o,
  input  var logic [63:0] pc_address_i,
  input  var logic [31:0] instruction_word_i,
  output logic            out_valid_o,
  input  var logic        out_stall_i,
  output logic [4:0]      operation_o,
  output logic [4:0]      dest_reg_o,
  output logic [4:0]      left_reg_o,
  output logic [5:0]      right_reg_o,
  output logic [3:0]      cond_code_o,
  output logic [5:0]      bit_position_o,
  output logic [5:0]      shift_amount_o,
  output logic [1:0]      shift_type_o,
  output logic [63:0]     immediate_value_o,
  output logic [63:0]     target_address_o,
  output logic [8:0]      memory_descriptor_o,
  output logic [7:0]      status_bits_o
);

  logic        adv;
  logic        v1_q, v2_q, v3_q;
  s1_t         s1_d, s1_q;
  s2_t         s2_d, s2_q;
  logic [31:0] w;
  logic [63:0] off;
  logic [64:0] bm;
  logic        ovf;
  logic [63:0] tgt;
  logic [7:0]  st;

  assign adv = !out_stall_i;
  assign in_stall_o = out_stall_i;
  assign w = instruction_word_i;

  always_comb begin
    s1_d = '0;
    s1_d.rule = match_rule(w);
    s1_d.word = w;
    s1_d.base = pc_address_i;
    off = '0;
    unique case (s1_d.rule)
      RULE_B: off = {{36{w[25]}}, w[25:0], 2'b00};
      RULE_BCOND, RULE_CB, RULE_LIT: off = {{43{w[23]}}, w[23:5], 2'b00};
      RULE_TB: off = {{48{w[18]}}, w[18:5], 2'b00};
      RULE_ADR: begin
        if (w[31]) begin
          off = {{31{w[23]}}, w[23:5], w[30:29], 12'd0};
          s1_d.base = {pc_address_i[63:12], 12'd0};
        end else begin
          off = {{43{w[23]}}, w[23:5], w[30:29]};
        end
      end
      default: off = '0;
    endcase
    s1_d.offset = off;
    s1_d.has_tgt = s1_d.rule == RULE_B || s1_d.rule == RULE_BCOND || s1_d.rule == RULE_CB ||
                   s1_d.rule == RULE_TB || s1_d.rule == RULE_ADR ||
                   (s1_d.rule == RULE_LIT && w[31:30] != 2'd3);
  end

  aic_decode u_decode (
    .s1_i(s1_q),
    .s2_o(s2_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  always_comb begin
    bm = bitmask_imm(s2_q.wide, s2_q.bm_n, s2_q.bm_r, s2_q.bm_s);
    // Positive offsets overflow on carry out; negative ones when no borrow-free wrap occurs.
    ovf = s2_q.off_neg ? !s2_q.sum[64] : s2_q.sum[64];
    tgt = (s2_q.has_tgt && !ovf) ? s2_q.sum[63:0] : 64'd0;
    st = s2_q.status;
    st[4] = s2_q.has_tgt && !ovf;
    st[5] = s2_q.wide;
    if (s2_q.logi && !bm[64]) st[0] = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      operation_o <= s2_q.op;
      dest_reg_o <= s2_q.dst;
      left_reg_o <= s2_q.lft;
      right_reg_o <= s2_q.rgt;
      cond_code_o <= s2_q.cond;
      bit_position_o <= s2_q.bitp;
      shift_amount_o <= s2_q.sh;
      shift_type_o <= s2_q.sht;
      immediate_value_o <= s2_q.logi ? bm[63:0] : (s2_q.imm_is_tgt ? tgt : s2_q.imm);
      target_address_o <= tgt;
      memory_descriptor_o <= s2_q.mem;
      status_bits_o <= st;
    end
  end

  assign out_valid_o = v3_q;

  a_unknown_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && operation_o == OP_UNKNOWN |-> !status_bits_o[0]) else $error("unknown valid");
  a_target_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_bits_o[4] |-> target_address_o == 64'd0) else $error("stale target");
  a_call_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_bits_o[2] |-> status_bits_o[6] && status_bits_o[3])
    else $error("call flags");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall_i |=> $stable(v3_q) && $stable(v2_q)) else $error("pipeline moved on stall");

endmodule
`default_nettype wire
